>>> rtl/ipsl_pkg.sv
// shared widths, reset values, register indexes and types for the incremental pid speed loop
package ipsl_pkg;

	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 5;
	localparam int REG_IDX_W  = ADDR_W - 2;
	localparam int GAIN_W     = 31;
	localparam int CMD_W      = 32;
	localparam int POS_W      = 32;
	localparam int GOAL_W     = 25;
	localparam int ERR_W      = 34;
	localparam int DIFF_W     = 35;
	localparam int ESUM_W     = 48;
	localparam int ESUM_WIDE_W = ESUM_W + 1;
	localparam int HALF_W     = ESUM_W / 2;
	localparam int PP_W       = HALF_W + GAIN_W;
	localparam int PROD_W     = ESUM_W + GAIN_W;
	localparam int TERM_W     = 62;
	localparam int SUM_W      = 64;
	localparam int TERM_LIMIT_BIT = 60;

	localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = 31'd32212;
	localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = 31'd139586;
	localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = 31'd0;
	localparam logic signed [CMD_W-1:0] CMD_MAX_RST = 32'sd536870912;
	localparam logic signed [CMD_W-1:0] CMD_MIN_RST = -32'sd536870912;

	localparam logic signed [ESUM_W-1:0] ESUM_MAX = {1'b0, {(ESUM_W-1){1'b1}}};
	localparam logic signed [ESUM_W-1:0] ESUM_MIN = {1'b1, {(ESUM_W-1){1'b0}}};
	localparam logic [PROD_W-1:0] TERM_LIMIT = PROD_W'(1) << TERM_LIMIT_BIT;

	localparam logic [REG_IDX_W-1:0] REG_GAIN_PROP  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_DERIV = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_INTEG = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CMD_MAX    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CMD_MIN    = 3'd4;

	typedef struct packed {
		logic mul;
		logic sat;
	} mul_en_t;

endpackage

>>> rtl/ipsl_term_mul.sv
// two-stage saturating signed-by-gain multiplier for one pid term
module ipsl_term_mul
	import ipsl_pkg::*;
(
	input  logic                     clk,
	input  mul_en_t                  en,
	input  logic signed [ESUM_W-1:0] x,
	input  logic        [GAIN_W-1:0] gain,
	output logic signed [TERM_W-1:0] term
);

	logic [ESUM_W-1:0] x_u;
	logic [ESUM_W-1:0] mag;
	logic [PP_W-1:0]   lo_pp_s3;
	logic [PP_W-1:0]   hi_pp_s3;
	logic              neg_s3;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] prod_sat;
	logic [TERM_W-1:0] tmag;
	logic signed [TERM_W-1:0] term_s4;

	assign x_u = x;
	assign mag = x_u[ESUM_W-1] ? (~x_u + ESUM_W'(1)) : x_u;

	always_ff @(posedge clk) begin
		if (en.mul) begin
			lo_pp_s3 <= PP_W'(mag[HALF_W-1:0]) * PP_W'(gain);
			hi_pp_s3 <= PP_W'(mag[ESUM_W-1:HALF_W]) * PP_W'(gain);
			neg_s3   <= x_u[ESUM_W-1];
		end
	end

	assign prod     = (PROD_W'(hi_pp_s3) << HALF_W) + PROD_W'(lo_pp_s3);
	assign prod_sat = (prod > TERM_LIMIT) ? TERM_LIMIT : prod;
	assign tmag     = prod_sat[TERM_W-1:0];

	always_ff @(posedge clk) begin
		if (en.sat) begin
			term_s4 <= neg_s3 ? (~tmag + TERM_W'(1)) : tmag;
		end
	end

	assign term = term_s4;

endmodule

>>> rtl/incremental_pid_speed_loop_unit.sv
// top level of the incremental pid speed loop: config registers, pipeline and clamp
//
// usage
// - input channel: in_valid with encoder_count and goal_delta, one transfer per
//   control period; in_stall high means the item is not taken this cycle
// - output channel: out_valid with drive_command and measured_delta, one result
//   per input item, in order; the receiver holds out_stall to keep it waiting
// - apb port: five registers at byte offsets 0x00..0x10 (gain_prop, gain_deriv,
//   gain_integ, command_max, command_min); write them only while the loop is idle
// - a result reaches the output through stages 1 to 5 and then the output register
// - throughput: one item per cycle unless a receiver stall holds the pipeline; the
//   multipliers are split into two stages and the only item-to-item loops (position,
//   error, error sum, last command) each close within one stage
// - when the receiver stalls, the pipeline keeps filling its empty stages and
//   in_stall rises only once every stage holds an item
// - reset clears all loop state to zero, loads the default gains and clamps and
//   empties the pipeline
module incremental_pid_speed_loop_unit
	import ipsl_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic        [ADDR_W-1:0] paddr,
	input  logic        [DATA_W-1:0] pwdata,
	output logic        [DATA_W-1:0] prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [POS_W-1:0]  encoder_count,
	input  logic signed [GOAL_W-1:0] goal_delta,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [CMD_W-1:0]  drive_command,
	output logic signed [POS_W-1:0]  measured_delta
);

	logic [GAIN_W-1:0]        gain_prop_q;
	logic [GAIN_W-1:0]        gain_deriv_q;
	logic [GAIN_W-1:0]        gain_integ_q;
	logic signed [CMD_W-1:0]  command_max_q;
	logic signed [CMD_W-1:0]  command_min_q;
	logic [REG_IDX_W-1:0]     reg_idx;
	logic                     cfg_wr;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, out_valid_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;

	logic [POS_W-1:0]          last_pos_q;
	logic [POS_W-1:0]          pos_next;
	logic signed [GOAL_W-1:0]  goal_s1;
	logic signed [POS_W-1:0]   delta_s1, delta_s2, delta_s3, delta_s4, delta_s5;
	logic signed [POS_W-1:0]   measured_delta_q;

	logic signed [ERR_W-1:0]       last_err_q;
	logic signed [ESUM_W-1:0]      esum_q;
	logic signed [ERR_W-1:0]       err_next;
	logic signed [DIFF_W-1:0]      diff_next;
	logic signed [ESUM_WIDE_W-1:0] esum_wide;
	logic signed [ESUM_W-1:0]      esum_next;
	logic signed [ERR_W-1:0]       err_s2;
	logic signed [DIFF_W-1:0]      diff_s2;
	logic signed [ESUM_W-1:0]      esum_s2;

	mul_en_t                   mul_en;
	logic signed [TERM_W-1:0]  term_prop, term_deriv, term_integ;
	logic signed [SUM_W-1:0]   tsum_s5;

	logic signed [SUM_W-1:0]   cmd_raw, cmd_hi, cmd_lo;
	logic signed [CMD_W-1:0]   drive_command_q;

	// apb register file
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q   <= GAIN_PROP_RST;
			gain_deriv_q  <= GAIN_DERIV_RST;
			gain_integ_q  <= GAIN_INTEG_RST;
			command_max_q <= CMD_MAX_RST;
			command_min_q <= CMD_MIN_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_GAIN_PROP:  gain_prop_q   <= pwdata[GAIN_W-1:0];
				REG_GAIN_DERIV: gain_deriv_q  <= pwdata[GAIN_W-1:0];
				REG_GAIN_INTEG: gain_integ_q  <= pwdata[GAIN_W-1:0];
				REG_CMD_MAX:    command_max_q <= pwdata[CMD_W-1:0];
				REG_CMD_MIN:    command_min_q <= pwdata[CMD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GAIN_PROP:  prdata = DATA_W'(gain_prop_q);
			REG_GAIN_DERIV: prdata = DATA_W'(gain_deriv_q);
			REG_GAIN_INTEG: prdata = DATA_W'(gain_integ_q);
			REG_CMD_MAX:    prdata = DATA_W'(command_max_q);
			REG_CMD_MIN:    prdata = DATA_W'(command_min_q);
			default:        prdata = '0;
		endcase
	end

	// pipeline flow control
	assign rdy_out = !out_valid_q || !out_stall;
	assign rdy5    = !vld_s5 || rdy_out;
	assign rdy4    = !vld_s4 || rdy5;
	assign rdy3    = !vld_s3 || rdy4;
	assign rdy2    = !vld_s2 || rdy3;
	assign rdy1    = !vld_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1)    vld_s1      <= in_valid;
			if (rdy2)    vld_s2      <= vld_s1;
			if (rdy3)    vld_s3      <= vld_s2;
			if (rdy4)    vld_s4      <= vld_s3;
			if (rdy5)    vld_s5      <= vld_s4;
			if (rdy_out) out_valid_q <= vld_s5;
		end
	end

	// stage 1: position and wrapped delta
	assign pos_next = '0 - encoder_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q <= '0;
		end else if (rdy1 && in_valid) begin
			last_pos_q <= pos_next;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			goal_s1  <= goal_delta;
			delta_s1 <= pos_next - last_pos_q;
		end
	end

	// stage 2: error, error difference and saturating error sum
	assign err_next  = ERR_W'(goal_s1) - ERR_W'(delta_s1);
	assign diff_next = DIFF_W'(err_next) - DIFF_W'(last_err_q);
	assign esum_wide = ESUM_WIDE_W'(esum_q) + ESUM_WIDE_W'(err_next);

	always_comb begin
		if (esum_wide[ESUM_WIDE_W-1] != esum_wide[ESUM_W-1]) begin
			esum_next = esum_wide[ESUM_WIDE_W-1] ? ESUM_MIN : ESUM_MAX;
		end else begin
			esum_next = esum_wide[ESUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= '0;
			esum_q     <= '0;
		end else if (rdy2 && vld_s1) begin
			last_err_q <= err_next;
			esum_q     <= esum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			err_s2   <= err_next;
			diff_s2  <= diff_next;
			esum_s2  <= esum_next;
			delta_s2 <= delta_s1;
		end
	end

	// stages 3 and 4: gain products
	assign mul_en.mul = rdy3;
	assign mul_en.sat = rdy4;

	ipsl_term_mul u_mul_prop (
		.clk  (clk),
		.en   (mul_en),
		.x    (ESUM_W'(err_s2)),
		.gain (gain_prop_q),
		.term (term_prop)
	);

	ipsl_term_mul u_mul_deriv (
		.clk  (clk),
		.en   (mul_en),
		.x    (ESUM_W'(diff_s2)),
		.gain (gain_deriv_q),
		.term (term_deriv)
	);

	ipsl_term_mul u_mul_integ (
		.clk  (clk),
		.en   (mul_en),
		.x    (esum_s2),
		.gain (gain_integ_q),
		.term (term_integ)
	);

	always_ff @(posedge clk) begin
		if (rdy3) delta_s3 <= delta_s2;
		if (rdy4) delta_s4 <= delta_s3;
	end

	// stage 5: term sum
	always_ff @(posedge clk) begin
		if (rdy5) begin
			tsum_s5  <= SUM_W'(term_prop) + SUM_W'(term_deriv) + SUM_W'(term_integ);
			delta_s5 <= delta_s4;
		end
	end

	// output: add to last command and clamp, max first then min
	assign cmd_raw = SUM_W'(drive_command_q) + tsum_s5;
	assign cmd_hi  = (cmd_raw > SUM_W'(command_max_q)) ? SUM_W'(command_max_q) : cmd_raw;
	assign cmd_lo  = (cmd_hi < SUM_W'(command_min_q)) ? SUM_W'(command_min_q) : cmd_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_command_q <= '0;
		end else if (rdy_out && vld_s5) begin
			drive_command_q <= cmd_lo[CMD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out) measured_delta_q <= delta_s5;
	end

	assign out_valid      = out_valid_q;
	assign drive_command  = drive_command_q;
	assign measured_delta = measured_delta_q;

	// checks
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && out_valid_q))
		else $error("input stalled with an empty pipeline stage");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_s1)
		else $error("accepted transfer did not reach stage 1");

	a_out_from_s5: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(vld_s5))
		else $error("result appeared without a stage 5 item");

	a_cmd_above_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drive_command >= command_min_q))
		else $error("drive command below lower clamp");

endmodule
